// ----- src/amrb_pkg.sv -----
// Shared types and constants for the audio mixing ring buffer.
// Used by amrb_mac and the top level audio_mixing_ring_buffer.
package amrb_pkg;

  localparam int RING_FRAMES_DEF  = 65536;
  localparam int MAX_CHANNELS_DEF = 4;
  localparam int MAX_BLOCK_DEF    = 4096;
  localparam int DEFAULT_CAPACITY = 48000;
  localparam int DEFAULT_CHANNELS = 2;

  localparam int WORD_W     = 24;
  localparam int SMP_W      = 16;
  localparam int GAIN_W     = 16;
  localparam int POS_W      = 64;
  localparam int N_SRC      = 4;
  localparam int N_OUT      = 4;
  localparam int IDX_W      = 12;
  localparam int BLK_W      = 13;
  localparam int SRCCH_W    = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int RCH_W      = 3;
  localparam int RCAP_W     = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd2;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_CLEAR = 10'b00_0000_0010,
    S_PLACE = 10'b00_0000_0100,
    S_ADDR  = 10'b00_0000_1000,
    S_ROW   = 10'b00_0001_0000,
    S_LOAD  = 10'b00_0010_0000,
    S_LANE  = 10'b00_0100_0000,
    S_WRITE = 10'b00_1000_0000,
    S_RREQ  = 10'b01_0000_0000,
    S_RLOAD = 10'b10_0000_0000
  } state_t;

endpackage

// ----- src/audio_mixing_ring_buffer.sv -----
// Audio mixing ring buffer top level: sequencer, positions, configuration.
// Depends on amrb_pkg, amrb_ram and amrb_mac.
//
// Usage:
//   Configuration words go in on cfg_valid/cfg_ready (ready is always high).
//   Index 0 enables monitoring; a rising enable latches channels and capacity
//   and starts a clearing pass over capacity rows, during which busy is high.
//   Items are taken when start is high and busy is low. A push (operation 0)
//   mixes one frame into the ring and gives no result; it keeps busy high through
//   placement, address, RAM read, one step per channel on the shared
//   multiply-accumulate unit, and the row write-back.
//   A read tick (operation 1) gives one result word on out_valid. With data in
//   the ring it reads and clears one RAM row: the strobe follows the request
//   and load states, busy staying high through both. On underrun or with
//   monitoring off the silence word comes in the cycle after acceptance.
//   Each result is on the out ports for exactly one cycle; the receiver cannot
//   stall. Reset leaves monitoring off with 2 channels and 48000 frames staged;
//   the ring holds nothing usable until monitoring is enabled.
module audio_mixing_ring_buffer
  import amrb_pkg::*;
#(
  parameter int RING_FRAMES  = RING_FRAMES_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int MAX_BLOCK    = MAX_BLOCK_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_operation,
  input  logic [IDX_W-1:0]         in_frame_index,
  input  logic [BLK_W-1:0]         in_block_frames,
  input  logic [SRCCH_W-1:0]       in_source_channels,
  input  logic [GAIN_W-1:0]        in_gain,
  input  logic signed [SMP_W-1:0]  in_sample_0,
  input  logic signed [SMP_W-1:0]  in_sample_1,
  input  logic signed [SMP_W-1:0]  in_sample_2,
  input  logic signed [SMP_W-1:0]  in_sample_3,
  output logic                     out_valid,
  output logic signed [WORD_W-1:0] out_0,
  output logic signed [WORD_W-1:0] out_1,
  output logic signed [WORD_W-1:0] out_2,
  output logic signed [WORD_W-1:0] out_3,
  output logic                     out_had_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  localparam int ROW_W   = $clog2(RING_FRAMES);
  localparam int CAP_W   = $clog2(RING_FRAMES + 1);
  localparam int CH_W    = $clog2(MAX_CHANNELS + 1);
  localparam int LANE_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int MB_W    = $clog2(MAX_BLOCK + 1);
  localparam int FW0     = (CAP_W > BLK_W) ? CAP_W : BLK_W;
  localparam int FW      = (MB_W > FW0) ? MB_W : FW0;
  localparam int CAPCW   = (CAP_W > RCAP_W) ? CAP_W : RCAP_W;
  localparam int RAM_W   = WORD_W * MAX_CHANNELS;
  localparam int CAP_RST = (DEFAULT_CAPACITY > RING_FRAMES) ? RING_FRAMES : DEFAULT_CAPACITY;
  localparam int CH_RST  = (DEFAULT_CHANNELS > MAX_CHANNELS) ? MAX_CHANNELS : DEFAULT_CHANNELS;

  // control state
  state_t            state_r, state_nxt;
  logic              en_r, en_nxt;
  logic              active_r, active_nxt;
  logic [RCH_W-1:0]  rch_r, rch_nxt;
  logic [RCAP_W-1:0] rcap_r, rcap_nxt;
  logic [CH_W-1:0]   act_ch_r, act_ch_nxt;
  logic [CAP_W-1:0]  act_cap_r, act_cap_nxt;
  logic [POS_W-1:0]  read_r, read_nxt;
  logic [POS_W-1:0]  write_r, write_nxt;
  logic [POS_W-1:0]  bs_r, bs_nxt;
  logic [ROW_W-1:0]  read_row_r, read_row_nxt;
  logic [ROW_W-1:0]  bs_row_r, bs_row_nxt;
  logic [ROW_W-1:0]  clr_r, clr_nxt;
  logic [LANE_W-1:0] lane_r, lane_nxt;
  logic              ovalid_r, ovalid_nxt;

  // payload
  logic [ROW_W-1:0]         pos_row_r, pos_row_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [CAP_W-1:0]         frames_r, frames_nxt;
  logic [SRCCH_W-1:0]       srcch_r, srcch_nxt;
  logic [GAIN_W-1:0]        gain_r, gain_nxt;
  logic signed [SMP_W-1:0]  smp_r [N_SRC];
  logic signed [SMP_W-1:0]  smp_nxt [N_SRC];
  logic [CAP_W-1:0]         offset_r, offset_nxt;
  logic signed [WORD_W-1:0] row_r [MAX_CHANNELS];
  logic signed [WORD_W-1:0] row_nxt [MAX_CHANNELS];
  logic signed [WORD_W-1:0] outd_r [N_OUT];
  logic signed [WORD_W-1:0] outd_nxt [N_OUT];
  logic                     had_r, had_nxt;

  // RAM ports
  logic             ram_we;
  logic [ROW_W-1:0] ram_waddr;
  logic [RAM_W-1:0] ram_wdata;
  logic [ROW_W-1:0] ram_raddr;
  logic [RAM_W-1:0] ram_rdata;
  logic [RAM_W-1:0] row_flat;

  logic signed [WORD_W-1:0] rd_lane [MAX_CHANNELS];
  logic signed [WORD_W-1:0] rd_out [N_OUT];

  // shared unit
  logic signed [SMP_W-1:0]  mac_sample;
  logic signed [WORD_W-1:0] mac_sum;
  logic [3:0]               lane4;
  logic                     use_own;

  // input decode
  logic [FW-1:0]    f_in, f_blk, f_cap;
  logic [CAP_W-1:0] frames_c;
  logic             push_ok;
  logic [3:0]       ch_z, ch_c;
  logic [CH_W-1:0]  ch_clamp;
  logic [CAPCW-1:0] cap_z, cap_c;
  logic [CAP_W-1:0] cap_clamp;

  // placement arithmetic
  logic [CAP_W+1:0] three_f;
  logic [CAP_W:0]   place_sum;
  logic [CAP_W:0]   pos_sum;
  logic [CAP_W:0]   rd_inc;
  logic [POS_W-1:0] blk_end;

  genvar g;

  generate
    for (g = 0; g < MAX_CHANNELS; g++) begin : g_lane
      assign rd_lane[g] = ram_rdata[g*WORD_W +: WORD_W];
      assign row_flat[g*WORD_W +: WORD_W] = row_r[g];
    end
    for (g = 0; g < N_OUT; g++) begin : g_out
      if (g < MAX_CHANNELS) begin : g_have
        assign rd_out[g] = rd_lane[g];
      end else begin : g_none
        assign rd_out[g] = '0;
      end
    end
  endgenerate

  amrb_ram #(
    .WIDTH(RAM_W),
    .DEPTH(RING_FRAMES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (1'b1),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // channels at or beyond the source count copy source channel 0
  assign lane4      = 4'(lane_r);
  assign use_own    = (lane4 < {1'b0, srcch_r}) && (lane4 < 4'(N_SRC));
  assign mac_sample = use_own ? smp_r[lane4[1:0]] : smp_r[0];

  amrb_mac u_mac (
    .sample(mac_sample),
    .gain  (gain_r),
    .acc   (row_r[lane_r]),
    .sum   (mac_sum)
  );

  // clamp block length to the block limit, then to the active capacity
  always_comb begin
    f_in     = FW'(in_block_frames);
    f_blk    = (f_in > FW'(MAX_BLOCK)) ? FW'(MAX_BLOCK) : f_in;
    f_cap    = (f_blk > FW'(act_cap_r)) ? FW'(act_cap_r) : f_blk;
    frames_c = CAP_W'(f_cap);
    push_ok  = active_r && (in_block_frames != '0) && (FW'(in_frame_index) < f_cap);
  end

  // geometry latched at enable
  always_comb begin
    ch_z      = (rch_r == '0) ? 4'(DEFAULT_CHANNELS) : {1'b0, rch_r};
    ch_c      = (ch_z > 4'(MAX_CHANNELS)) ? 4'(MAX_CHANNELS) : ch_z;
    ch_clamp  = CH_W'(ch_c);
    cap_z     = (rcap_r == '0) ? CAPCW'(DEFAULT_CAPACITY) : CAPCW'(rcap_r);
    cap_c     = (cap_z > CAPCW'(RING_FRAMES)) ? CAPCW'(RING_FRAMES) : cap_z;
    cap_clamp = CAP_W'(cap_c);
  end

  always_comb begin
    three_f   = ((CAP_W+2)'(frames_r) << 1) + (CAP_W+2)'(frames_r);
    place_sum = (CAP_W+1)'(read_row_r) + (CAP_W+1)'(offset_r);
    pos_sum   = (CAP_W+1)'(bs_row_r) + (CAP_W+1)'(idx_r);
    rd_inc    = (CAP_W+1)'(read_row_r) + (CAP_W+1)'(1);
    blk_end   = bs_r + POS_W'(frames_r);
  end

  always_comb begin
    state_nxt    = state_r;
    en_nxt       = en_r;
    active_nxt   = active_r;
    rch_nxt      = rch_r;
    rcap_nxt     = rcap_r;
    act_ch_nxt   = act_ch_r;
    act_cap_nxt  = act_cap_r;
    read_nxt     = read_r;
    write_nxt    = write_r;
    bs_nxt       = bs_r;
    read_row_nxt = read_row_r;
    bs_row_nxt   = bs_row_r;
    clr_nxt      = clr_r;
    lane_nxt     = lane_r;
    ovalid_nxt   = 1'b0;
    pos_row_nxt  = pos_row_r;
    idx_nxt      = idx_r;
    frames_nxt   = frames_r;
    srcch_nxt    = srcch_r;
    gain_nxt     = gain_r;
    offset_nxt   = offset_r;
    had_nxt      = had_r;
    smp_nxt      = smp_r;
    row_nxt      = row_r;
    outd_nxt     = outd_r;
    ram_we       = 1'b0;
    ram_waddr    = read_row_r;
    ram_wdata    = '0;
    ram_raddr    = read_row_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_operation == OP_PUSH) begin
            idx_nxt    = in_frame_index;
            frames_nxt = frames_c;
            srcch_nxt  = in_source_channels;
            gain_nxt   = in_gain;
            smp_nxt[0] = in_sample_0;
            smp_nxt[1] = in_sample_1;
            smp_nxt[2] = in_sample_2;
            smp_nxt[3] = in_sample_3;
            if (push_ok) begin
              state_nxt = S_PLACE;
            end
          end else if (active_r && (read_r < write_r)) begin
            state_nxt = S_RREQ;
          end else begin
            // underrun or monitoring off: silence word right away
            ovalid_nxt = 1'b1;
            had_nxt    = 1'b0;
            for (int k = 0; k < N_OUT; k++) begin
              outd_nxt[k] = '0;
            end
          end
        end
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        if (CAP_W'(clr_r) == act_cap_r - CAP_W'(1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + ROW_W'(1);
        end
      end
      S_PLACE: begin
        // pull the block back when two lengths ahead would lap the reader
        if (three_f > (CAP_W+2)'(act_cap_r)) begin
          offset_nxt = act_cap_r - frames_r;
        end else begin
          offset_nxt = CAP_W'(three_f - (CAP_W+2)'(frames_r));
        end
        state_nxt = S_ADDR;
      end
      S_ADDR: begin
        if (idx_r == '0) begin
          bs_nxt = read_r + POS_W'(offset_r);
          if (place_sum >= (CAP_W+1)'(act_cap_r)) begin
            bs_row_nxt = ROW_W'(place_sum - (CAP_W+1)'(act_cap_r));
          end else begin
            bs_row_nxt = ROW_W'(place_sum);
          end
        end
        state_nxt = S_ROW;
      end
      S_ROW: begin
        if (pos_sum >= (CAP_W+1)'(act_cap_r)) begin
          pos_row_nxt = ROW_W'(pos_sum - (CAP_W+1)'(act_cap_r));
        end else begin
          pos_row_nxt = ROW_W'(pos_sum);
        end
        ram_raddr = pos_row_nxt;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        row_nxt   = rd_lane;
        lane_nxt  = '0;
        state_nxt = S_LANE;
      end
      S_LANE: begin
        row_nxt[lane_r] = mac_sum;
        lane_nxt        = lane_r + LANE_W'(1);
        if (CH_W'(lane_r) == act_ch_r - CH_W'(1)) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = pos_row_r;
        ram_wdata = row_flat;
        // advance the write position at the block's last frame
        if ((FW'(idx_r) == FW'(frames_r) - FW'(1)) && (blk_end > write_r)) begin
          write_nxt = blk_end;
        end
        state_nxt = S_IDLE;
      end
      S_RREQ: begin
        ram_raddr = read_row_r;
        state_nxt = S_RLOAD;
      end
      S_RLOAD: begin
        ovalid_nxt = 1'b1;
        had_nxt    = 1'b1;
        for (int k = 0; k < N_OUT; k++) begin
          outd_nxt[k] = (k < int'(act_ch_r)) ? rd_out[k] : '0;
        end
        // drop the frame from the ring
        ram_we    = 1'b1;
        ram_waddr = read_row_r;
        ram_wdata = '0;
        read_nxt  = read_r + POS_W'(1);
        if (rd_inc == (CAP_W+1)'(act_cap_r)) begin
          read_row_nxt = '0;
        end else begin
          read_row_nxt = ROW_W'(rd_inc);
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ENABLE: begin
          en_nxt = cfg_data[0];
          if (cfg_data[0] && !en_r) begin
            active_nxt   = 1'b1;
            act_ch_nxt   = ch_clamp;
            act_cap_nxt  = cap_clamp;
            read_nxt     = '0;
            write_nxt    = '0;
            bs_nxt       = '0;
            read_row_nxt = '0;
            bs_row_nxt   = '0;
            clr_nxt      = '0;
            state_nxt    = S_CLEAR;
          end else if (!cfg_data[0]) begin
            active_nxt = 1'b0;
          end
        end
        CFG_CHANNELS: begin
          rch_nxt = cfg_data[RCH_W-1:0];
        end
        CFG_CAPACITY: begin
          rcap_nxt = cfg_data[RCAP_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      en_r       <= 1'b0;
      active_r   <= 1'b0;
      rch_r      <= RCH_W'(DEFAULT_CHANNELS);
      rcap_r     <= RCAP_W'(DEFAULT_CAPACITY);
      act_ch_r   <= CH_W'(CH_RST);
      act_cap_r  <= CAP_W'(CAP_RST);
      read_r     <= '0;
      write_r    <= '0;
      bs_r       <= '0;
      read_row_r <= '0;
      bs_row_r   <= '0;
      clr_r      <= '0;
      lane_r     <= '0;
      ovalid_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      en_r       <= en_nxt;
      active_r   <= active_nxt;
      rch_r      <= rch_nxt;
      rcap_r     <= rcap_nxt;
      act_ch_r   <= act_ch_nxt;
      act_cap_r  <= act_cap_nxt;
      read_r     <= read_nxt;
      write_r    <= write_nxt;
      bs_r       <= bs_nxt;
      read_row_r <= read_row_nxt;
      bs_row_r   <= bs_row_nxt;
      clr_r      <= clr_nxt;
      lane_r     <= lane_nxt;
      ovalid_r   <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_row_r <= pos_row_nxt;
    idx_r     <= idx_nxt;
    frames_r  <= frames_nxt;
    srcch_r   <= srcch_nxt;
    gain_r    <= gain_nxt;
    offset_r  <= offset_nxt;
    had_r     <= had_nxt;
    smp_r     <= smp_nxt;
    row_r     <= row_nxt;
    outd_r    <= outd_nxt;
  end

  assign busy         = (state_r != S_IDLE);
  assign cfg_ready    = 1'b1;
  assign out_valid    = ovalid_r;
  assign out_0        = outd_r[0];
  assign out_1        = outd_r[1];
  assign out_2        = outd_r[2];
  assign out_3        = outd_r[3];
  assign out_had_data = had_r;

endmodule

// ----- src/amrb_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module amrb_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/amrb_mac.sv -----
// Shared scale-and-accumulate unit: sample times Q4.12 gain, round half up,
// add into a 24-bit ring word with saturation. Depends on amrb_pkg.
module amrb_mac
  import amrb_pkg::*;
(
  input  logic signed [SMP_W-1:0]  sample,
  input  logic        [GAIN_W-1:0] gain,
  input  logic signed [WORD_W-1:0] acc,
  output logic signed [WORD_W-1:0] sum
);

  localparam int PROD_W = SMP_W + GAIN_W + 1;
  localparam int SCL_W  = PROD_W - 12;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rnd;
  logic signed [SCL_W-1:0]  scaled;
  logic signed [WORD_W:0]   wide;

  always_comb begin
    prod   = PROD_W'(sample) * PROD_W'(signed'({1'b0, gain}));
    rnd    = prod + PROD_W'(2048);
    // arithmetic shift floors, so this rounds half toward +infinity
    scaled = rnd[PROD_W-1:12];
    wide   = (WORD_W+1)'(acc) + (WORD_W+1)'(scaled);
    if (wide[WORD_W] != wide[WORD_W-1]) begin
      sum = wide[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
    end else begin
      sum = wide[WORD_W-1:0];
    end
  end

endmodule
